@@ hdl/stevp_pkg.sv @@
`timescale 1ns / 1ps

package stevp_pkg;

  // Track positions and the event limit.
  localparam int unsigned POS_BITS   = 21;
  localparam int unsigned MAX_EVENTS = 1048576;
  localparam int unsigned EVT_BITS   = $clog2(MAX_EVENTS + 1);

  localparam int unsigned DELTA_BITS     = 28;
  localparam int unsigned DELTA_MAX_BYTES = 4;
  localparam int unsigned OFF_BITS       = 32;
  localparam int unsigned ADDR_BITS      = 3;

  // Command codes, with the top bit of the command byte removed.
  localparam logic [6:0] CODE_LOOP_COUNT = 7'd6;
  localparam logic [6:0] CODE_SET_CHAN   = 7'd70;
  localparam logic [6:0] CODE_TEMPO      = 7'd71;
  localparam logic [6:0] CODE_BEND       = 7'd72;
  localparam logic [6:0] CODE_PROGRAM    = 7'd73;
  localparam logic [6:0] CODE_NOTE_OFF   = 7'd74;
  localparam logic [6:0] CODE_OFF_CHAIN  = 7'd75;
  localparam logic [6:0] CODE_LOOP_CTRL  = 7'd99;
  localparam logic [6:0] CODE_END        = 7'd127;

  // Loop controller arguments and the default loop count.
  localparam logic [6:0] LOOP_OPEN_VAL   = 7'd20;
  localparam logic [6:0] LOOP_CLOSE_VAL  = 7'd30;
  localparam logic [6:0] LOOP_DEFAULT    = 7'd127;

  // Register index of the track base.
  localparam logic REG_TRACK_BASE = 1'b0;

  typedef enum logic [2:0] {
    ST_EVENT     = 3'd0,
    ST_FINAL     = 3'd1,
    ST_TRUNCATED = 3'd2,
    ST_BAD_DELTA = 3'd3,
    ST_TRAILING  = 3'd4,
    ST_TOO_MANY  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    K_NOTE     = 3'd0,
    K_CTRL     = 3'd1,
    K_SET_CHAN = 3'd2,
    K_TEMPO    = 3'd3,
    K_BEND     = 3'd4,
    K_PROGRAM  = 3'd5,
    K_NOTE_OFF = 3'd6,
    K_END      = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    PH_DELTA = 2'd0,
    PH_CMD   = 2'd1,
    PH_VALUE = 2'd2
  } phase_e;

  // One raw track word as held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } in_word_t;

  // One result word.
  typedef struct packed {
    status_e               status;
    kind_e                 kind;
    logic [6:0]            code;
    logic [6:0]            value;
    logic [DELTA_BITS-1:0] delta;
    logic                  chained;
    logic [OFF_BITS-1:0]   start_off;
    logic [OFF_BITS-1:0]   end_off;
    logic                  has_loop;
    logic [OFF_BITS-1:0]   loop_target;
    logic [6:0]            loop_repeats;
  } result_t;

  // Map a command code to its event kind.
  function automatic kind_e kind_of(input logic [6:0] code);
    kind_e k;
    case (code)
      CODE_SET_CHAN:                k = K_SET_CHAN;
      CODE_TEMPO:                   k = K_TEMPO;
      CODE_BEND:                    k = K_BEND;
      CODE_PROGRAM:                 k = K_PROGRAM;
      CODE_NOTE_OFF, CODE_OFF_CHAIN: k = K_NOTE_OFF;
      CODE_END:                     k = K_END;
      default:                      k = K_CTRL;
    endcase
    return k;
  endfunction

endpackage

@@ hdl/stevp_apb.sv @@
`timescale 1ns / 1ps

module stevp_apb (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [stevp_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  output logic [stevp_pkg::OFF_BITS-1:0]       track_base_o
);
  import stevp_pkg::*;

  logic [OFF_BITS-1:0] base_q;
  logic                wr_en;

  // A write completes in the access cycle; only the track base exists.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TRACK_BASE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (wr_en) begin
      base_q <= pwdata;
    end
  end

  // Read back the track base; other addresses read as zero.
  assign prdata       = (paddr[2] == REG_TRACK_BASE) ? base_q : 32'd0;
  assign track_base_o = base_q;

endmodule

@@ hdl/stevp_in_reg.sv @@
`timescale 1ns / 1ps

module stevp_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  input  logic                take_i,
  output stevp_pkg::in_word_t word_o
);
  import stevp_pkg::*;

  logic       valid_q;
  logic [7:0] data_q;
  logic       last_q;
  logic       load;

  // The held word leaves whenever the parse stage takes it.
  assign load       = !valid_q || take_i;
  assign in_stall_o = !load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload carries no reset.
  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      data_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  assign word_o = {valid_q, data_q, last_q};

endmodule

@@ hdl/stevp_parse.sv @@
`timescale 1ns / 1ps

module stevp_parse (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  stevp_pkg::in_word_t            word_i,
  output logic                           take_o,
  input  logic [stevp_pkg::OFF_BITS-1:0] track_base_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output stevp_pkg::result_t             result_o
);
  import stevp_pkg::*;

  // Parse state.
  phase_e                phase_q, phase_d;
  logic [DELTA_BITS-1:0] accum_q, accum_d;
  logic [2:0]            cnt_q, cnt_d;
  logic [7:0]            held_q, held_d;
  logic [POS_BITS-1:0]   begin_q, begin_d;
  logic                  loop_open_q, loop_open_d;
  logic [POS_BITS-1:0]   loop_pos_q, loop_pos_d;
  logic [6:0]            loop_cnt_q, loop_cnt_d;
  logic                  loop_fixed_q, loop_fixed_d;
  logic [POS_BITS-1:0]   pos_q, pos_d;
  logic [EVT_BITS-1:0]   events_q, events_d;
  logic                  halted_q, halted_d;

  // Result register.
  logic    out_valid_q;
  result_t res_q, res_d;

  logic                out_free;
  logic                fire;
  logic                produce;
  logic                err;
  status_e             err_status;
  logic                complete;
  logic                clear;
  logic                too_many;
  logic [POS_BITS-1:0] next_pos;
  logic [7:0]          b;
  logic                last;
  logic [7:0]          cmd;
  logic [6:0]          code;
  logic [6:0]          value;
  logic                chained;
  kind_e               kind;
  logic [OFF_BITS-1:0] start_off;
  logic [OFF_BITS-1:0] end_off;
  logic [OFF_BITS-1:0] loop_off;

  // A word is processed whenever the result register can take a new word.
  assign out_free = !out_valid_q || !out_stall_i;
  assign take_o   = out_free;
  assign fire     = word_i.valid && out_free;

  assign b        = word_i.data;
  assign last     = word_i.last;
  assign next_pos = pos_q + POS_BITS'(1);
  assign too_many = (events_q >= EVT_BITS'(MAX_EVENTS)) && (phase_q != PH_VALUE)
                    && (cnt_q == 3'd0);

  // File offsets, relative to the configured track base.
  assign start_off = track_base_i + OFF_BITS'(begin_q);
  assign end_off   = track_base_i + OFF_BITS'(next_pos);
  assign loop_off  = track_base_i + OFF_BITS'(loop_pos_q);

  // Next state and result for the held word.
  always_comb begin
    phase_d      = phase_q;
    accum_d      = accum_q;
    cnt_d        = cnt_q;
    held_d       = held_q;
    begin_d      = begin_q;
    loop_open_d  = loop_open_q;
    loop_pos_d   = loop_pos_q;
    loop_cnt_d   = loop_cnt_q;
    loop_fixed_d = loop_fixed_q;
    pos_d        = pos_q;
    events_d     = events_q;
    halted_d     = halted_q;
    res_d        = '0;
    produce      = 1'b0;
    err          = 1'b0;
    err_status   = ST_TRUNCATED;
    complete     = 1'b0;
    clear        = 1'b0;
    cmd          = held_q;
    value        = 7'd0;
    chained      = 1'b0;

    if (halted_q) begin
      // Drop words up to and including the marked last word.
      clear = last;
    end else if (too_many) begin
      err        = 1'b1;
      err_status = ST_TOO_MANY;
    end else begin
      case (phase_q)
        PH_DELTA: begin
          accum_d = {accum_q[DELTA_BITS-8:0], b[6:0]};
          cnt_d   = cnt_q + 3'd1;
          pos_d   = next_pos;
          if (b[7]) begin
            if (cnt_q >= 3'(DELTA_MAX_BYTES - 1)) begin
              err        = 1'b1;
              err_status = ST_BAD_DELTA;
            end
          end else begin
            phase_d = PH_CMD;
          end
          if (!err && last) begin
            err        = 1'b1;
            err_status = ST_TRUNCATED;
          end
        end
        PH_CMD: begin
          held_d = b;
          pos_d  = next_pos;
          if (b[7] && (b[6:0] == CODE_NOTE_OFF || b[6:0] == CODE_OFF_CHAIN)) begin
            cmd      = b;
            value    = 7'd0;
            chained  = (b[6:0] == CODE_OFF_CHAIN);
            complete = 1'b1;
          end else begin
            phase_d = PH_VALUE;
            if (last) begin
              err        = 1'b1;
              err_status = ST_TRUNCATED;
            end
          end
        end
        PH_VALUE: begin
          pos_d    = next_pos;
          value    = b[6:0];
          chained  = b[7];
          complete = 1'b1;
        end
        default: begin
          phase_d = PH_DELTA;
        end
      endcase
    end

    code = cmd[6:0];
    kind = cmd[7] ? kind_of(code) : K_NOTE;

    // An error reports the unfinished event and stops the track.
    if (err) begin
      produce          = 1'b1;
      res_d.status     = err_status;
      res_d.start_off  = start_off;
      res_d.end_off    = end_off;
      if (last) begin
        clear = 1'b1;
      end else begin
        halted_d = 1'b1;
      end
    end

    // A finished event, with loop bookkeeping.
    if (complete) begin
      produce = 1'b1;
      if (kind == K_CTRL && code == CODE_LOOP_CTRL) begin
        if (value == LOOP_OPEN_VAL) begin
          loop_open_d  = 1'b1;
          loop_pos_d   = next_pos;
          loop_cnt_d   = LOOP_DEFAULT;
          loop_fixed_d = 1'b0;
        end else if (value == LOOP_CLOSE_VAL && loop_open_q) begin
          res_d.has_loop     = 1'b1;
          res_d.loop_target  = loop_off;
          res_d.loop_repeats = loop_cnt_q;
          loop_open_d        = 1'b0;
        end
      end else if (kind == K_CTRL && code == CODE_LOOP_COUNT && loop_open_q &&
                   !loop_fixed_q) begin
        loop_cnt_d   = value;
        loop_fixed_d = 1'b1;
      end
      if (last) begin
        res_d.status = ST_FINAL;
      end else if (kind == K_END) begin
        res_d.status = ST_TRAILING;
      end else begin
        res_d.status = ST_EVENT;
      end
      res_d.kind      = kind;
      res_d.code      = code;
      res_d.value     = value;
      res_d.delta     = accum_q;
      res_d.chained   = chained;
      res_d.start_off = start_off;
      res_d.end_off   = end_off;
      events_d        = events_q + EVT_BITS'(1);
      phase_d         = chained ? PH_CMD : PH_DELTA;
      accum_d         = '0;
      cnt_d           = 3'd0;
      begin_d         = next_pos;
      if (last) begin
        clear = 1'b1;
      end else if (kind == K_END) begin
        halted_d = 1'b1;
      end
    end

    // A fresh track starts from cleared state.
    if (clear) begin
      phase_d      = PH_DELTA;
      accum_d      = '0;
      cnt_d        = 3'd0;
      held_d       = 8'd0;
      begin_d      = '0;
      loop_open_d  = 1'b0;
      loop_pos_d   = '0;
      loop_cnt_d   = 7'd0;
      loop_fixed_d = 1'b0;
      pos_d        = '0;
      events_d     = '0;
      halted_d     = 1'b0;
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_DELTA;
      accum_q      <= '0;
      cnt_q        <= 3'd0;
      held_q       <= 8'd0;
      begin_q      <= '0;
      loop_open_q  <= 1'b0;
      loop_pos_q   <= '0;
      loop_cnt_q   <= 7'd0;
      loop_fixed_q <= 1'b0;
      pos_q        <= '0;
      events_q     <= '0;
      halted_q     <= 1'b0;
    end else if (fire) begin
      phase_q      <= phase_d;
      accum_q      <= accum_d;
      cnt_q        <= cnt_d;
      held_q       <= held_d;
      begin_q      <= begin_d;
      loop_open_q  <= loop_open_d;
      loop_pos_q   <= loop_pos_d;
      loop_cnt_q   <= loop_cnt_d;
      loop_fixed_q <= loop_fixed_d;
      pos_q        <= pos_d;
      events_q     <= events_d;
      halted_q     <= halted_d;
    end
  end

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire && produce;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (fire && produce) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

@@ hdl/sequence_track_event_parser_core.sv @@
`timescale 1ns / 1ps
// A result word is registered in the result register when the parse stage takes the
// word from the input register that completes it.
// Throughput: one track word per cycle; the parse stage takes a word whenever the
// result register is empty or being read.
// Reset: rst_ni clears the parse state, both valid flags and the track base.
// After a final event, or a marked word ending an error or dropped words, the next word starts a fresh track.
module sequence_track_event_parser_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [7:0]                           data_byte_i,
  input  logic                                 last_byte_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [2:0]                           status_o,
  output logic [2:0]                           event_kind_o,
  output logic [6:0]                           command_code_o,
  output logic [6:0]                           event_value_o,
  output logic [27:0]                          delta_ticks_o,
  output logic                                 is_chained_o,
  output logic [31:0]                          start_offset_o,
  output logic [31:0]                          end_offset_o,
  output logic                                 has_loop_o,
  output logic [31:0]                          loop_target_o,
  output logic [6:0]                           loop_repeats_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [stevp_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import stevp_pkg::*;

  in_word_t            word;
  logic                take;
  logic [OFF_BITS-1:0] track_base;
  result_t             res;

  stevp_apb u_apb (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .track_base_o (track_base)
  );

  stevp_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .take_i      (take),
    .word_o      (word)
  );

  stevp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_i       (word),
    .take_o       (take),
    .track_base_i (track_base),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (res)
  );

  // Unpack the result word onto the output ports.
  assign status_o       = res.status;
  assign event_kind_o   = res.kind;
  assign command_code_o = res.code;
  assign event_value_o  = res.value;
  assign delta_ticks_o  = res.delta;
  assign is_chained_o   = res.chained;
  assign start_offset_o = res.start_off;
  assign end_offset_o   = res.end_off;
  assign has_loop_o     = res.has_loop;
  assign loop_target_o  = res.loop_target;
  assign loop_repeats_o = res.loop_repeats;

endmodule

@@ test/sequence_track_event_parser_core_tb.sv @@
`timescale 1ns / 1ps

module sequence_track_event_parser_core_tb;
  import stevp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RESET_CYCLES = 6;
  localparam int MAX_IDLE     = 6;
  localparam int PHASE_BYTES  = 130;
  localparam int CHOKE_AT     = 120;
  localparam int CHOKE_CYCLES = 80;
  localparam int SETTLE_WAIT  = 4;
  localparam int DRAIN_LIMIT  = 4000;
  localparam int MAX_PRINTS   = 40;

  localparam logic [ADDR_BITS-1:0] BASE_ADDR  = {REG_TRACK_BASE, 2'b00};
  localparam logic [ADDR_BITS-1:0] SPARE_ADDR = 3'd4;

  // Command bytes carry the top bit; value bytes use it to chain the next event.
  localparam logic [7:0] CHAIN_BIT     = 8'h80;
  localparam logic [7:0] CMD_COUNT     = {1'b1, CODE_LOOP_COUNT};
  localparam logic [7:0] CMD_SET_CHAN  = {1'b1, CODE_SET_CHAN};
  localparam logic [7:0] CMD_TEMPO     = {1'b1, CODE_TEMPO};
  localparam logic [7:0] CMD_BEND      = {1'b1, CODE_BEND};
  localparam logic [7:0] CMD_PROGRAM   = {1'b1, CODE_PROGRAM};
  localparam logic [7:0] CMD_NOTE_OFF  = {1'b1, CODE_NOTE_OFF};
  localparam logic [7:0] CMD_OFF_CHAIN = {1'b1, CODE_OFF_CHAIN};
  localparam logic [7:0] CMD_LOOP      = {1'b1, CODE_LOOP_CTRL};
  localparam logic [7:0] CMD_END       = {1'b1, CODE_END};

  localparam result_t NO_WANT = '0;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         typed;
    result_t    want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [2:0]  event_kind_o;
  logic [6:0]  command_code_o;
  logic [6:0]  event_value_o;
  logic [27:0] delta_ticks_o;
  logic        is_chained_o;
  logic [31:0] start_offset_o;
  logic [31:0] end_offset_o;
  logic        has_loop_o;
  logic [31:0] loop_target_o;
  logic [6:0]  loop_repeats_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Parser state mirrored on the bench side.
  logic [31:0]           trk_base;
  phase_e                ph;
  logic [DELTA_BITS-1:0] d_accum;
  logic [2:0]            d_count;
  logic [7:0]            cmd_hold;
  logic [POS_BITS-1:0]   ev_begin;
  logic                  loop_armed;
  logic [POS_BITS-1:0]   loop_origin;
  logic [6:0]            loop_reps;
  logic                  reps_locked;
  logic [POS_BITS-1:0]   cursor;
  logic [POS_BITS-1:0]   ev_total;
  logic                  dropping;

  result_t    events_due[$];
  logic [8:0] track_words[$];
  int         mismatches = 0;
  int         cycle_count = 0;
  int         bytes_taken = 0;
  int         hold_left;
  bit         sender_idles;
  bit         receiver_idles;
  bit         choke_on;

  // Directed track bytes; rows with a typed result check against that value.
  stim_row_t dir_rows [56] = '{
    '{8'h00, 1'b0, 1'b0, NO_WANT},
    '{8'h3c, 1'b0, 1'b0, NO_WANT},
    '{8'h40, 1'b0, 1'b1, '{ST_EVENT, K_NOTE, 7'h3c, 7'h40, 28'd0, 1'b0, 32'd0, 32'd3,
                         1'b0, 32'd0, 7'd0}},
    '{8'hff, 1'b0, 1'b0, NO_WANT},
    '{8'hff, 1'b0, 1'b0, NO_WANT},
    '{8'hff, 1'b0, 1'b0, NO_WANT},
    '{8'h7f, 1'b0, 1'b0, NO_WANT},
    '{8'h7f, 1'b0, 1'b0, NO_WANT},
    '{8'hff, 1'b0, 1'b1, '{ST_EVENT, K_NOTE, 7'h7f, 7'h7f, 28'hfffffff, 1'b1, 32'd3, 32'd9,
                         1'b0, 32'd0, 7'd0}},
    '{CMD_LOOP, 1'b0, 1'b0, NO_WANT},
    '{CHAIN_BIT | LOOP_OPEN_VAL, 1'b0, 1'b0, NO_WANT},
    '{CMD_COUNT, 1'b0, 1'b0, NO_WANT},
    '{8'h85, 1'b0, 1'b0, NO_WANT},
    '{CMD_COUNT, 1'b0, 1'b0, NO_WANT},
    '{8'h89, 1'b0, 1'b0, NO_WANT},
    '{CMD_OFF_CHAIN, 1'b0, 1'b0, NO_WANT},
    '{CMD_TEMPO, 1'b0, 1'b0, NO_WANT},
    '{8'h81, 1'b0, 1'b0, NO_WANT},
    '{CMD_SET_CHAN, 1'b0, 1'b0, NO_WANT},
    '{8'h82, 1'b0, 1'b0, NO_WANT},
    '{CMD_BEND, 1'b0, 1'b0, NO_WANT},
    '{8'h83, 1'b0, 1'b0, NO_WANT},
    '{CMD_PROGRAM, 1'b0, 1'b0, NO_WANT},
    '{8'h84, 1'b0, 1'b0, NO_WANT},
    '{CMD_LOOP, 1'b0, 1'b0, NO_WANT},
    '{CHAIN_BIT | LOOP_CLOSE_VAL, 1'b0, 1'b1, '{ST_EVENT, K_CTRL, CODE_LOOP_CTRL,
                         LOOP_CLOSE_VAL, 28'd0, 1'b1, 32'd24, 32'd26, 1'b1, 32'd11, 7'd5}},
    '{CMD_NOTE_OFF, 1'b0, 1'b0, NO_WANT},
    '{8'h00, 1'b0, 1'b0, NO_WANT},
    '{CMD_END, 1'b0, 1'b0, NO_WANT},
    '{8'h00, 1'b1, 1'b1, '{ST_FINAL, K_END, CODE_END, 7'd0, 28'd0, 1'b0, 32'd27, 32'd30,
                         1'b0, 32'd0, 7'd0}},
    '{8'h00, 1'b0, 1'b0, NO_WANT},
    '{CMD_END, 1'b0, 1'b0, NO_WANT},
    '{8'h00, 1'b0, 1'b1, '{ST_TRAILING, K_END, CODE_END, 7'd0, 28'd0, 1'b0, 32'd0, 32'd3,
                         1'b0, 32'd0, 7'd0}},
    '{8'h55, 1'b0, 1'b0, NO_WANT},
    '{8'h12, 1'b1, 1'b0, NO_WANT},
    '{8'h80, 1'b0, 1'b0, NO_WANT},
    '{8'h80, 1'b0, 1'b0, NO_WANT},
    '{8'h80, 1'b0, 1'b0, NO_WANT},
    '{8'h80, 1'b0, 1'b1, '{ST_BAD_DELTA, K_NOTE, 7'd0, 7'd0, 28'd0, 1'b0, 32'd0, 32'd4,
                         1'b0, 32'd0, 7'd0}},
    '{8'h00, 1'b1, 1'b0, NO_WANT},
    '{8'h05, 1'b0, 1'b0, NO_WANT},
    '{8'h90, 1'b1, 1'b1, '{ST_TRUNCATED, K_NOTE, 7'd0, 7'd0, 28'd0, 1'b0, 32'd0, 32'd2,
                         1'b0, 32'd0, 7'd0}},
    '{8'h80, 1'b0, 1'b0, NO_WANT},
    '{8'h80, 1'b0, 1'b0, NO_WANT},
    '{8'h80, 1'b0, 1'b0, NO_WANT},
    '{8'h80, 1'b1, 1'b1, '{ST_BAD_DELTA, K_NOTE, 7'd0, 7'd0, 28'd0, 1'b0, 32'd0, 32'd4,
                         1'b0, 32'd0, 7'd0}},
    '{8'h00, 1'b0, 1'b0, NO_WANT},
    '{CMD_LOOP, 1'b0, 1'b0, NO_WANT},
    '{8'(LOOP_CLOSE_VAL), 1'b0, 1'b0, NO_WANT},
    '{8'h00, 1'b0, 1'b0, NO_WANT},
    '{CMD_LOOP, 1'b0, 1'b0, NO_WANT},
    '{8'(LOOP_OPEN_VAL), 1'b0, 1'b0, NO_WANT},
    '{8'h00, 1'b0, 1'b0, NO_WANT},
    '{CMD_LOOP, 1'b0, 1'b0, NO_WANT},
    '{8'(LOOP_CLOSE_VAL), 1'b1, 1'b1, '{ST_FINAL, K_CTRL, CODE_LOOP_CTRL, LOOP_CLOSE_VAL,
                         28'd0, 1'b0, 32'd6, 32'd9, 1'b1, 32'd6, LOOP_DEFAULT}},
    '{8'h83, 1'b1, 1'b1, '{ST_TRUNCATED, K_NOTE, 7'd0, 7'd0, 28'd0, 1'b0, 32'd0, 32'd1,
                         1'b0, 32'd0, 7'd0}}
  };

  sequence_track_event_parser_core DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop if the run hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic log_mismatch(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
  endtask

  // A fresh track clears everything except the base offset.
  task automatic restart_track();
    ph          = PH_DELTA;
    d_accum     = '0;
    d_count     = '0;
    cmd_hold    = '0;
    ev_begin    = '0;
    loop_armed  = 1'b0;
    loop_origin = '0;
    loop_reps   = '0;
    reps_locked = 1'b0;
    cursor      = '0;
    ev_total    = '0;
    dropping    = 1'b0;
  endtask

  function automatic kind_e kind_for(input logic [6:0] code);
    case (code)
      CODE_SET_CHAN:                 return K_SET_CHAN;
      CODE_TEMPO:                    return K_TEMPO;
      CODE_BEND:                     return K_BEND;
      CODE_PROGRAM:                  return K_PROGRAM;
      CODE_NOTE_OFF, CODE_OFF_CHAIN: return K_NOTE_OFF;
      CODE_END:                      return K_END;
      default:                       return K_CTRL;
    endcase
  endfunction

  // An error word carries only the status and the two offsets.
  task automatic flag_error(input status_e st, input logic [POS_BITS-1:0] nxt,
                            input logic lst, output result_t r);
    r = '0;
    r.status    = st;
    r.start_off = trk_base + 32'(ev_begin);
    r.end_off   = trk_base + 32'(nxt);
    if (lst)
      restart_track();
    else
      dropping = 1'b1;
  endtask

  // Advance the parse by one track byte and work out the word it produces, if any.
  task automatic parse_track_byte(input logic [7:0] b, input logic lst, output bit emits,
                                  output result_t r);
    logic [POS_BITS-1:0] nxt;
    logic [6:0]          code;
    logic [6:0]          val;
    kind_e               kind;
    bit                  chained;
    nxt     = cursor + 1'b1;
    emits   = 1'b0;
    r       = '0;
    val     = '0;
    chained = 1'b0;
    if (dropping) begin
      if (lst)
        restart_track();
      return;
    end
    emits = 1'b1;
    if (ev_total >= MAX_EVENTS && ph != PH_VALUE && d_count == 0) begin
      flag_error(ST_TOO_MANY, nxt, lst, r);
      return;
    end

    // Delta bytes accumulate seven bits each, most significant first.
    if (ph == PH_DELTA) begin
      d_accum = {d_accum[DELTA_BITS-8:0], b[6:0]};
      d_count = d_count + 1'b1;
      cursor  = nxt;
      if (b[7] && d_count >= DELTA_MAX_BYTES) begin
        flag_error(ST_BAD_DELTA, nxt, lst, r);
        return;
      end
      if (!b[7])
        ph = PH_CMD;
      if (lst)
        flag_error(ST_TRUNCATED, nxt, lst, r);
      else
        emits = 1'b0;
      return;
    end

    // Note-off commands complete without a value byte.
    if (ph == PH_CMD) begin
      cmd_hold = b;
      cursor   = nxt;
      if (b[7] && (b[6:0] == CODE_NOTE_OFF || b[6:0] == CODE_OFF_CHAIN)) begin
        chained = (b[6:0] == CODE_OFF_CHAIN);
      end else begin
        ph = PH_VALUE;
        if (lst)
          flag_error(ST_TRUNCATED, nxt, lst, r);
        else
          emits = 1'b0;
        return;
      end
    end else begin
      cursor  = nxt;
      val     = b[6:0];
      chained = b[7];
    end

    code = cmd_hold[6:0];
    kind = cmd_hold[7] ? kind_for(code) : K_NOTE;

    // Loop controllers: open, set the count once, close.
    if (kind == K_CTRL && code == CODE_LOOP_CTRL) begin
      if (val == LOOP_OPEN_VAL) begin
        loop_armed  = 1'b1;
        loop_origin = nxt;
        loop_reps   = LOOP_DEFAULT;
        reps_locked = 1'b0;
      end else if (val == LOOP_CLOSE_VAL && loop_armed) begin
        r.has_loop     = 1'b1;
        r.loop_target  = trk_base + 32'(loop_origin);
        r.loop_repeats = loop_reps;
        loop_armed     = 1'b0;
      end
    end else if (kind == K_CTRL && code == CODE_LOOP_COUNT && loop_armed && !reps_locked) begin
      loop_reps   = val;
      reps_locked = 1'b1;
    end

    r.status    = lst ? ST_FINAL : (kind == K_END ? ST_TRAILING : ST_EVENT);
    r.kind      = kind;
    r.code      = code;
    r.value     = val;
    r.delta     = d_accum;
    r.chained   = chained;
    r.start_off = trk_base + 32'(ev_begin);
    r.end_off   = trk_base + 32'(nxt);

    ev_total   = ev_total + 1'b1;
    ph         = chained ? PH_CMD : PH_DELTA;
    d_accum    = '0;
    d_count    = '0;
    ev_begin   = nxt;
    if (r.status == ST_FINAL)
      restart_track();
    else if (r.status == ST_TRAILING)
      dropping = 1'b1;
  endtask

  // Offer one byte, after a random gap if the sender idles, and hold it until the block takes it.
  task automatic send_byte(input logic [7:0] b, input logic lst, output bit emits,
                           output result_t r);
    int gap;
    gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  = 1'b1;
    data_byte_i = b;
    last_byte_i = lst;
    do
      @(posedge clk_i);
    while (in_stall_o);
    bytes_taken++;
    parse_track_byte(b, lst, emits, r);
  endtask

  task automatic feed(input logic [7:0] b, input logic lst);
    result_t r;
    bit      emits;
    send_byte(b, lst, emits, r);
    if (emits)
      events_due.insert(events_due.size(), r);
  endtask

  // Compare one accepted result word with the oldest pending event.
  task automatic check_word();
    result_t got;
    result_t want;
    got = {status_o, event_kind_o, command_code_o, event_value_o, delta_ticks_o,
           is_chained_o, start_offset_o, end_offset_o, has_loop_o, loop_target_o,
           loop_repeats_o};
    if (events_due.size() == 0) begin
      log_mismatch("word with no event pending, status", got.status, '0);
      return;
    end
    want = events_due.pop_front();
    if (got.status !== want.status) log_mismatch("status", got.status, want.status);
    if (got.kind !== want.kind) log_mismatch("event_kind", got.kind, want.kind);
    if (got.code !== want.code) log_mismatch("command_code", got.code, want.code);
    if (got.value !== want.value) log_mismatch("event_value", got.value, want.value);
    if (got.delta !== want.delta) log_mismatch("delta_ticks", got.delta, want.delta);
    if (got.chained !== want.chained) log_mismatch("is_chained", got.chained, want.chained);
    if (got.start_off !== want.start_off)
      log_mismatch("start_offset", got.start_off, want.start_off);
    if (got.end_off !== want.end_off) log_mismatch("end_offset", got.end_off, want.end_off);
    if (got.has_loop !== want.has_loop) log_mismatch("has_loop", got.has_loop, want.has_loop);
    if (got.loop_target !== want.loop_target)
      log_mismatch("loop_target", got.loop_target, want.loop_target);
    if (got.loop_repeats !== want.loop_repeats)
      log_mismatch("loop_repeats", got.loop_repeats, want.loop_repeats);
  endtask

  // Result side: take words and stall for a random count after each one.
  initial begin
    out_stall_i = 1'b0;
    hold_left   = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
        check_word();
        hold_left = receiver_idles ? $urandom_range(0, MAX_IDLE) : 0;
      end
      @(negedge clk_i);
      out_stall_i = choke_on || hold_left > 0;
      if (hold_left > 0 && !choke_on)
        hold_left--;
    end
  end

  // One long stall on the result side so the block backs up into its input.
  initial begin
    choke_on = 1'b0;
    wait (bytes_taken >= CHOKE_AT);
    @(posedge clk_i);
    choke_on = 1'b1;
    repeat (CHOKE_CYCLES) @(posedge clk_i);
    choke_on = 1'b0;
  end

  task automatic apb_access(input logic wr, input logic [ADDR_BITS-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = addr;
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do
      @(posedge clk_i);
    while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Write a register, then read the track base back.
  task automatic set_track_base(input logic [ADDR_BITS-1:0] addr, input logic [31:0] value);
    logic [31:0] rd;
    apb_access(1'b1, addr, value, rd);
    if (addr == BASE_ADDR)
      trk_base = value;
    apb_access(1'b0, BASE_ADDR, '0, rd);
    if (rd !== trk_base)
      log_mismatch("track_base readback", rd, trk_base);
  endtask

  // Stop offering bytes and wait for every pending event, then let the pipe settle.
  task automatic drain();
    int waited;
    waited = 0;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (events_due.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  // Build one track: mostly well-formed events with random content, some noise.
  task automatic build_track();
    int         n_ev;
    int         nb;
    int         keep;
    int         e;
    int         k;
    bit         chained;
    bit         bad;
    logic [7:0] cmd;
    logic [7:0] val;
    logic [8:0] w;
    track_words.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12))
        track_words.insert(track_words.size(), {1'b0, 8'($urandom)});
    end else begin
      n_ev    = $urandom_range(1, 10);
      chained = 1'b0;
      for (e = 0; e < n_ev; e++) begin
        if (!chained) begin
          bad = ($urandom_range(0, 39) == 0);
          nb  = bad ? 4 : (($urandom_range(0, 5) == 0) ? $urandom_range(2, 4) : 1);
          for (k = 0; k < nb; k++)
            track_words.insert(track_words.size(),
                               {1'b0, (k < nb - 1 || bad), 7'($urandom)});
        end
        case ($urandom_range(0, 9))
          0, 1, 2, 3: cmd = {1'b0, 7'($urandom)};
          4:          cmd = {1'b1, 7'(CODE_SET_CHAN + 7'($urandom_range(0, 3)))};
          5:          cmd = $urandom_range(0, 1) ? CMD_NOTE_OFF : CMD_OFF_CHAIN;
          6:          cmd = CMD_COUNT;
          7, 8:       cmd = CMD_LOOP;
          default:    cmd = {1'b1, 7'($urandom)};
        endcase
        if (e == n_ev - 1 && $urandom_range(0, 9) < 7)
          cmd = CMD_END;
        track_words.insert(track_words.size(), {1'b0, cmd});
        if (cmd == CMD_NOTE_OFF || cmd == CMD_OFF_CHAIN) begin
          chained = (cmd == CMD_OFF_CHAIN);
        end else begin
          val = 8'($urandom_range(0, 127));
          if (cmd == CMD_LOOP && $urandom_range(0, 3) != 0)
            val = $urandom_range(0, 1) ? 8'(LOOP_OPEN_VAL) : 8'(LOOP_CLOSE_VAL);
          if ($urandom_range(0, 4) == 0)
            val = val | CHAIN_BIT;
          chained = val[7];
          track_words.insert(track_words.size(), {1'b0, val});
        end
      end
      // Some tracks end early to exercise truncation.
      if ($urandom_range(0, 6) == 0) begin
        keep = $urandom_range(1, track_words.size());
        while (track_words.size() > keep)
          void'(track_words.pop_back());
      end
    end
    w    = track_words.pop_back();
    w[8] = 1'b1;
    track_words.insert(track_words.size(), w);
  endtask

  task automatic run_phase(input int n_bytes);
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      build_track();
      foreach (track_words[i])
        feed(track_words[i][7:0], track_words[i][8]);
      sent += track_words.size();
    end
  endtask

  // Main sequence: reset, directed track bytes, then random phases at several bases.
  initial begin
    result_t r;
    bit      emits;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    data_byte_i    = '0;
    last_byte_i    = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    trk_base       = '0;
    restart_track();
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data, dir_rows[i].last, emits, r);
      if (emits)
        events_due.insert(events_due.size(), dir_rows[i].typed ? dir_rows[i].want : r);
    end
    drain();

    set_track_base(BASE_ADDR, 32'hffff_ffff);
    run_phase(PHASE_BYTES);
    drain();

    // Back to back on both sides.
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    set_track_base(BASE_ADDR, $urandom);
    set_track_base(SPARE_ADDR, $urandom);
    run_phase(PHASE_BYTES);
    drain();

    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    set_track_base(BASE_ADDR, 32'h0000_0000);
    run_phase(PHASE_BYTES);
    drain();

    if (events_due.size() != 0)
      log_mismatch("events never delivered", events_due.size(), '0);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
